@@ hdl/led_driver_serial_write_sequencer_macros.svh @@
// Assertion helpers used by the sequencer top module.
`ifndef LED_DRIVER_SERIAL_WRITE_SEQUENCER_MACROS_SVH
`define LED_DRIVER_SERIAL_WRITE_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only out of reset.
`define LDSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define LDSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LDSW_ASSERT(lbl, prop, msg)
`define LDSW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/ldsw_pkg.sv @@
package ldsw_pkg;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_COMMAND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CONTROL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_MAX    = 2'd2;

  localparam int CFG_DATA_W = 27;
  localparam int TIMEOUT_W  = 27;

  localparam logic [7:0]           DATA_COMMAND_RST    = 8'h40;
  localparam logic [7:0]           DISPLAY_CONTROL_RST = 8'h8A;
  localparam logic [TIMEOUT_W-1:0] ACK_WAIT_MAX_RST    = 27'd100000000;

  // Line timing in ticks
  localparam int HALF_BIT_TICKS   = 3;
  localparam int SETUP_TICKS      = 2;
  localparam int ACK_SETTLE_TICKS = 5;

  localparam logic [2:0] HALF_BIT_DLY   = 3'(HALF_BIT_TICKS - 1);
  localparam logic [2:0] SETUP_DLY      = 3'(SETUP_TICKS - 1);
  localparam logic [2:0] ACK_SETTLE_DLY = 3'(ACK_SETTLE_TICKS - 1);
  localparam logic [2:0] ONE_TICK_DLY   = 3'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic [7:0] byte_value;
    logic [7:0] start_address;
    logic [2:0] byte_count;
    logic       dio_sample;
  } ldsw_item_t;

  typedef struct packed {
    logic                 clk_line;
    logic                 dio_line;
    logic                 busy_res;
    logic                 done_res;
    logic                 ack_fail;
  } ldsw_res_t;

  typedef struct packed {
    logic [7:0]           data_command;
    logic [7:0]           display_control;
    logic [TIMEOUT_W-1:0] ack_wait_max;
  } ldsw_cfg_t;

endpackage

@@ hdl/ldsw_if.sv @@
interface ldsw_in_if import ldsw_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] slot;
  logic [7:0] byte_value;
  logic [7:0] start_address;
  logic [2:0] byte_count;
  logic       dio_sample;

  modport source (output valid, kind, slot, byte_value, start_address, byte_count,
                  dio_sample, input ready);
  modport sink (input valid, kind, slot, byte_value, start_address, byte_count,
                dio_sample, output ready);
endinterface

interface ldsw_out_if import ldsw_pkg::*; ();
  logic valid;
  logic ready;
  logic clk_line;
  logic dio_line;
  logic busy_res;
  logic done_res;
  logic ack_fail;

  modport source (output valid, clk_line, dio_line, busy_res, done_res, ack_fail,
                  input ready);
  modport sink (input valid, clk_line, dio_line, busy_res, done_res, ack_fail,
                output ready);
endinterface

interface ldsw_cfg_if import ldsw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/led_driver_serial_write_sequencer.sv @@
// Latency: the result word of an accepted item is valid on the next cycle.
// Throughput: one item per cycle; the output register frees in the cycle its
// word is taken, so input ready only drops while a result waits unread.
// Reset (rst_n low, synchronous): sequencer idle, both lines released high,
// registers back to 0x40 / 0x8A / 100000000; the display bytes are not cleared.
`include "led_driver_serial_write_sequencer_macros.svh"

module led_driver_serial_write_sequencer import ldsw_pkg::*; #(
  parameter int MAX_BYTES = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  ldsw_in_if.sink     in_ch,
  ldsw_out_if.source  out_ch,
  ldsw_cfg_if.sink    cfg_ch
);

  ldsw_cfg_t  cfg;
  ldsw_item_t item;
  ldsw_res_t  res;
  ldsw_res_t  res_r;
  logic       out_valid_r;
  logic       in_acc;

  assign item.kind          = in_ch.kind;
  assign item.slot          = in_ch.slot;
  assign item.byte_value    = in_ch.byte_value;
  assign item.start_address = in_ch.start_address;
  assign item.byte_count    = in_ch.byte_count;
  assign item.dio_sample    = in_ch.dio_sample;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  ldsw_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ldsw_seq #(
    .MAX_BYTES (MAX_BYTES)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_acc),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.clk_line = res_r.clk_line;
  assign out_ch.dio_line = res_r.dio_line;
  assign out_ch.busy_res = res_r.busy_res;
  assign out_ch.done_res = res_r.done_res;
  assign out_ch.ack_fail = res_r.ack_fail;

  `LDSW_ASSERT(a_acc_gives_word, in_acc |=> out_ch.valid, "accepted item produced no word")
  `LDSW_ASSERT(a_done_not_busy, out_ch.valid |-> !(out_ch.done_res && out_ch.busy_res),
               "done reported while still busy")
  `LDSW_ASSERT(a_done_not_fail, out_ch.valid |-> !(out_ch.done_res && out_ch.ack_fail),
               "done reported on a failed transfer")
  `LDSW_ASSERT(a_word_kept, (out_ch.valid && !out_ch.ready) |=> out_ch.valid,
               "unread word dropped")
  `LDSW_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_ch.valid, "word valid after reset")

endmodule

@@ hdl/ldsw_cfg_regs.sv @@
module ldsw_cfg_regs import ldsw_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  ldsw_cfg_if.sink       cfg_ch,
  output ldsw_cfg_t      cfg
);

  logic [7:0]           data_command_r;
  logic [7:0]           display_control_r;
  logic [TIMEOUT_W-1:0] ack_wait_max_r;
  logic                 wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_command_r    <= DATA_COMMAND_RST;
      display_control_r <= DISPLAY_CONTROL_RST;
      ack_wait_max_r    <= ACK_WAIT_MAX_RST;
    end else if (wr_en) begin
      case (cfg_ch.index)
        CFG_DATA_COMMAND:    data_command_r    <= cfg_ch.data[7:0];
        CFG_DISPLAY_CONTROL: display_control_r <= cfg_ch.data[7:0];
        CFG_ACK_WAIT_MAX:    ack_wait_max_r    <= cfg_ch.data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.data_command    = data_command_r;
  assign cfg.display_control = display_control_r;
  assign cfg.ack_wait_max    = ack_wait_max_r;

endmodule

@@ hdl/ldsw_seq.sv @@
module ldsw_seq import ldsw_pkg::*; #(
  parameter int MAX_BYTES = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  ldsw_item_t item,
  input  ldsw_cfg_t  cfg,
  output ldsw_res_t  res
);

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_HI, PH_START_LO, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_SETTLE,
    PH_ACK_WAIT, PH_ACK_CLK, PH_ACK_END, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [2:0]           dly_r, dly_nxt;
  logic [2:0]           bit_idx_r, bit_idx_nxt;
  logic [CW-1:0]        byte_idx_r, byte_idx_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [TIMEOUT_W-1:0] wait_r, wait_nxt;
  logic [7:0]           addr_r, addr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [1:0]           frame_r, frame_nxt;
  logic                 clk_r, clk_nxt;
  logic                 dio_r, dio_nxt;
  logic                 fail_r, fail_nxt;
  logic                 done;
  logic                 load_en;
  logic [7:0]           disp_mem_r [MAX_BYTES];
  logic [7:0]           fetch_byte;
  logic                 ack_poll;

  assign fetch_byte = disp_mem_r[byte_idx_r[AW-1:0]];
  assign ack_poll   = (phase_r == PH_ACK_WAIT) ||
                      ((phase_r == PH_ACK_SETTLE) && (dly_r == 3'd0));

  always_comb begin
    phase_nxt    = phase_r;
    dly_nxt      = dly_r;
    bit_idx_nxt  = bit_idx_r;
    byte_idx_nxt = byte_idx_r;
    shift_nxt    = shift_r;
    wait_nxt     = wait_r;
    addr_nxt     = addr_r;
    count_nxt    = count_r;
    frame_nxt    = frame_r;
    clk_nxt      = clk_r;
    dio_nxt      = dio_r;
    fail_nxt     = fail_r;
    done         = 1'b0;
    load_en      = 1'b0;

    case (item.kind)
      KIND_TICK: begin
        if (phase_r != PH_IDLE) begin
          if (ack_poll) begin
            phase_nxt = PH_ACK_WAIT;
            if (!item.dio_sample) begin
              phase_nxt = PH_ACK_CLK;
              clk_nxt   = 1'b1;
              dio_nxt   = 1'b1;
              dly_nxt   = SETUP_DLY;
            end else begin
              wait_nxt = TIMEOUT_W'(wait_r + 1'b1);
              if (wait_nxt >= cfg.ack_wait_max) begin
                // abort without a stop condition
                fail_nxt  = 1'b1;
                phase_nxt = PH_IDLE;
                dly_nxt   = 3'd0;
              end
            end
          end else if (dly_r != 3'd0) begin
            dly_nxt = dly_r - 3'd1;
          end else begin
            case (phase_r)
              PH_START_HI: begin
                phase_nxt = PH_START_LO;
                clk_nxt   = 1'b1;
                dio_nxt   = 1'b0;
                dly_nxt   = ONE_TICK_DLY;
              end
              PH_START_LO: begin
                case (frame_r)
                  2'd0:    shift_nxt = cfg.data_command;
                  2'd1:    shift_nxt = addr_r;
                  default: shift_nxt = cfg.display_control;
                endcase
                bit_idx_nxt = 3'd0;
                phase_nxt   = PH_BIT_LOW;
                clk_nxt     = 1'b0;
                dio_nxt     = shift_nxt[0];
                dly_nxt     = HALF_BIT_DLY;
              end
              PH_BIT_LOW: begin
                phase_nxt = PH_BIT_HIGH;
                clk_nxt   = 1'b1;
                dly_nxt   = HALF_BIT_DLY;
              end
              PH_BIT_HIGH: begin
                if (bit_idx_r == 3'd7) begin
                  // release DIO for the acknowledge
                  wait_nxt  = '0;
                  phase_nxt = PH_ACK_SETTLE;
                  clk_nxt   = 1'b0;
                  dio_nxt   = 1'b1;
                  dly_nxt   = ACK_SETTLE_DLY;
                end else begin
                  bit_idx_nxt = bit_idx_r + 3'd1;
                  shift_nxt   = {1'b0, shift_r[7:1]};
                  phase_nxt   = PH_BIT_LOW;
                  clk_nxt     = 1'b0;
                  dio_nxt     = shift_r[1];
                  dly_nxt     = HALF_BIT_DLY;
                end
              end
              PH_ACK_CLK: begin
                phase_nxt = PH_ACK_END;
                clk_nxt   = 1'b0;
                dio_nxt   = 1'b1;
                dly_nxt   = ONE_TICK_DLY;
              end
              PH_ACK_END: begin
                if ((frame_r == 2'd1) && (byte_idx_r < count_r) &&
                    (32'(byte_idx_r) < MAX_BYTES)) begin
                  byte_idx_nxt = byte_idx_r + 1'b1;
                  shift_nxt    = fetch_byte;
                  bit_idx_nxt  = 3'd0;
                  phase_nxt    = PH_BIT_LOW;
                  clk_nxt      = 1'b0;
                  dio_nxt      = fetch_byte[0];
                  dly_nxt      = HALF_BIT_DLY;
                end else begin
                  phase_nxt = PH_STOP_A;
                  clk_nxt   = 1'b0;
                  dio_nxt   = 1'b1;
                  dly_nxt   = SETUP_DLY;
                end
              end
              PH_STOP_A: begin
                phase_nxt = PH_STOP_B;
                clk_nxt   = 1'b0;
                dio_nxt   = 1'b0;
                dly_nxt   = SETUP_DLY;
              end
              PH_STOP_B: begin
                phase_nxt = PH_STOP_C;
                clk_nxt   = 1'b1;
                dio_nxt   = 1'b0;
                dly_nxt   = SETUP_DLY;
              end
              PH_STOP_C: begin
                clk_nxt = 1'b1;
                dio_nxt = 1'b1;
                if (frame_r >= 2'd2) begin
                  phase_nxt = PH_IDLE;
                  dly_nxt   = ONE_TICK_DLY;
                  done      = 1'b1;
                end else begin
                  frame_nxt = frame_r + 2'd1;
                  phase_nxt = PH_START_HI;
                  dly_nxt   = SETUP_DLY;
                end
              end
              default: begin
                phase_nxt = PH_IDLE;
                dly_nxt   = 3'd0;
              end
            endcase
          end
        end
      end
      KIND_LOAD: begin
        if ((phase_r == PH_IDLE) && (32'(item.slot) < MAX_BYTES)) begin
          load_en = 1'b1;
        end
      end
      KIND_START: begin
        if (phase_r == PH_IDLE) begin
          addr_nxt     = item.start_address;
          count_nxt    = (32'(item.byte_count) > MAX_BYTES) ? CW'(MAX_BYTES)
                                                            : CW'(item.byte_count);
          byte_idx_nxt = '0;
          frame_nxt    = 2'd0;
          fail_nxt     = 1'b0;
          wait_nxt     = '0;
          phase_nxt    = PH_START_HI;
          clk_nxt      = 1'b1;
          dio_nxt      = 1'b1;
          dly_nxt      = SETUP_DLY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      dly_r      <= 3'd0;
      bit_idx_r  <= 3'd0;
      byte_idx_r <= '0;
      shift_r    <= 8'd0;
      wait_r     <= '0;
      addr_r     <= 8'd0;
      count_r    <= '0;
      frame_r    <= 2'd0;
      clk_r      <= 1'b1;
      dio_r      <= 1'b1;
      fail_r     <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      dly_r      <= dly_nxt;
      bit_idx_r  <= bit_idx_nxt;
      byte_idx_r <= byte_idx_nxt;
      shift_r    <= shift_nxt;
      wait_r     <= wait_nxt;
      addr_r     <= addr_nxt;
      count_r    <= count_nxt;
      frame_r    <= frame_nxt;
      clk_r      <= clk_nxt;
      dio_r      <= dio_nxt;
      fail_r     <= fail_nxt;
    end
  end

  // display bytes: no reset; the block does not check that a sent slot was ever loaded
  always_ff @(posedge clk) begin
    if (step_en && load_en) begin
      disp_mem_r[AW'(item.slot)] <= item.byte_value;
    end
  end

  assign res.clk_line = clk_nxt;
  assign res.dio_line = dio_nxt;
  assign res.busy_res = (phase_nxt != PH_IDLE);
  assign res.done_res = done;
  assign res.ack_fail = fail_nxt;

endmodule

@@ tb/tb_led_driver_serial_write_sequencer.sv @@
module tb_led_driver_serial_write_sequencer import ldsw_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_DEPTH     = 6;
  localparam int RUN_LIMIT     = 400000;
  localparam int RAND_PER_MODE = 100;

  localparam logic [1:0]           KIND_UNUSED   = 2'd3;
  localparam logic [TIMEOUT_W-1:0] ACK_LIMIT_MAX = '1;

  // Result word bit order: clk_line, dio_line, busy_res, done_res, ack_fail
  localparam ldsw_res_t RES_IDLE    = 5'b11000;
  localparam ldsw_res_t RES_START   = 5'b11100;
  localparam ldsw_res_t RES_ABORTED = 5'b01001;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_START_HI, SQ_START_LO, SQ_BIT_LOW, SQ_BIT_HIGH, SQ_ACK_SETTLE,
    SQ_ACK_WAIT, SQ_ACK_CLK, SQ_ACK_END, SQ_STOP_A, SQ_STOP_B, SQ_STOP_C
  } seq_phase_e;

  typedef enum {ROW_WORD, ROW_REG} row_op_e;
  typedef enum {AFTER_NONE, AFTER_ACK, AFTER_SILENT} after_e;

  typedef struct {
    row_op_e               op;
    ldsw_item_t            word;
    bit                    typed;
    ldsw_res_t             want;
    after_e                after;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ldsw_in_if  in_ch ();
  ldsw_out_if out_ch ();
  ldsw_cfg_if cfg_ch ();

  led_driver_serial_write_sequencer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sequencer copy
  logic [7:0]           cmd_byte;
  logic [7:0]           ctl_byte;
  logic [TIMEOUT_W-1:0] ack_limit;
  seq_phase_e           sq_phase;
  logic [2:0]           sq_dly;
  logic [2:0]           sq_bit;
  logic [2:0]           sq_byte_idx;
  logic [7:0]           sq_shift;
  logic [7:0]           seg_buf [BUF_DEPTH];
  logic [TIMEOUT_W-1:0] sq_wait;
  logic [7:0]           sq_addr;
  logic [2:0]           sq_cnt;
  logic [1:0]           sq_frame;
  logic                 line_clk;
  logic                 line_dio;
  logic                 fail_flag;

  ldsw_res_t expected_lines [$];
  plan_row_t plan [$];

  int  send_gap_pct   = 25;
  int  recv_stall_pct = 46;
  bit  hold_once      = 1'b1;
  int  cycle_count    = 0;
  int  words_sent     = 0;
  int  words_checked  = 0;
  int  transfers_done = 0;
  int  aborts         = 0;
  int  mismatches     = 0;

  function automatic void enter_state(seq_phase_e ph, logic c, logic d, logic [2:0] dly);
    sq_phase = ph;
    line_clk = c;
    line_dio = d;
    sq_dly   = dly;
  endfunction

  function automatic void load_shift(logic [7:0] v);
    sq_shift = v;
    sq_bit   = 3'd0;
    enter_state(SQ_BIT_LOW, 1'b0, v[0], HALF_BIT_DLY);
  endfunction

  // One tick of a busy sequencer; returns 1 when the final stop completes.
  function automatic logic step_sequencer(logic dio);
    logic finished;
    finished = 1'b0;
    // settle over: this tick already samples DIO
    if (sq_phase == SQ_ACK_SETTLE && sq_dly == 3'd0) sq_phase = SQ_ACK_WAIT;
    if (sq_phase == SQ_ACK_WAIT) begin
      if (!dio) begin
        enter_state(SQ_ACK_CLK, 1'b1, 1'b1, SETUP_DLY);
      end else begin
        sq_wait = sq_wait + 1'b1;
        if (sq_wait >= ack_limit) begin
          fail_flag = 1'b1;
          sq_phase  = SQ_IDLE;
          sq_dly    = 3'd0;
          aborts++;
        end
      end
    end else if (sq_dly != 3'd0) begin
      sq_dly--;
    end else begin
      case (sq_phase)
        SQ_START_HI: enter_state(SQ_START_LO, 1'b1, 1'b0, ONE_TICK_DLY);
        SQ_START_LO: begin
          if (sq_frame == 2'd0) load_shift(cmd_byte);
          else if (sq_frame == 2'd1) load_shift(sq_addr);
          else load_shift(ctl_byte);
        end
        SQ_BIT_LOW: enter_state(SQ_BIT_HIGH, 1'b1, line_dio, HALF_BIT_DLY);
        SQ_BIT_HIGH: begin
          if (sq_bit >= 3'd7) begin
            sq_wait = '0;
            enter_state(SQ_ACK_SETTLE, 1'b0, 1'b1, ACK_SETTLE_DLY);
          end else begin
            sq_bit++;
            sq_shift = sq_shift >> 1;
            enter_state(SQ_BIT_LOW, 1'b0, sq_shift[0], HALF_BIT_DLY);
          end
        end
        SQ_ACK_CLK: enter_state(SQ_ACK_END, 1'b0, 1'b1, ONE_TICK_DLY);
        SQ_ACK_END: begin
          if (sq_frame == 2'd1 && sq_byte_idx < sq_cnt && sq_byte_idx < BUF_DEPTH) begin
            load_shift(seg_buf[sq_byte_idx]);
            sq_byte_idx++;
          end else begin
            enter_state(SQ_STOP_A, 1'b0, 1'b1, SETUP_DLY);
          end
        end
        SQ_STOP_A: enter_state(SQ_STOP_B, 1'b0, 1'b0, SETUP_DLY);
        SQ_STOP_B: enter_state(SQ_STOP_C, 1'b1, 1'b0, SETUP_DLY);
        SQ_STOP_C: begin
          if (sq_frame >= 2'd2) begin
            enter_state(SQ_IDLE, 1'b1, 1'b1, ONE_TICK_DLY);
            finished = 1'b1;
          end else begin
            sq_frame++;
            enter_state(SQ_START_HI, 1'b1, 1'b1, SETUP_DLY);
          end
        end
        default: begin
          sq_phase = SQ_IDLE;
          sq_dly   = 3'd0;
        end
      endcase
    end
    return finished;
  endfunction

  function automatic ldsw_res_t apply_word(ldsw_item_t w);
    ldsw_res_t r;
    logic      finished;
    finished = 1'b0;
    case (w.kind)
      KIND_TICK: begin
        if (sq_phase != SQ_IDLE) finished = step_sequencer(w.dio_sample);
      end
      KIND_LOAD: begin
        if (sq_phase == SQ_IDLE && w.slot < BUF_DEPTH) seg_buf[w.slot] = w.byte_value;
      end
      KIND_START: begin
        if (sq_phase == SQ_IDLE) begin
          sq_addr     = w.start_address;
          sq_cnt      = (w.byte_count > BUF_DEPTH) ? 3'(BUF_DEPTH) : w.byte_count;
          sq_byte_idx = 3'd0;
          sq_frame    = 2'd0;
          fail_flag   = 1'b0;
          sq_wait     = '0;
          enter_state(SQ_START_HI, 1'b1, 1'b1, SETUP_DLY);
        end
      end
      default: ;
    endcase
    if (finished) transfers_done++;
    r.clk_line = line_clk;
    r.dio_line = line_dio;
    r.busy_res = (sq_phase != SQ_IDLE);
    r.done_res = finished;
    r.ack_fail = fail_flag;
    return r;
  endfunction

  function automatic ldsw_item_t rand_item(logic [1:0] k);
    ldsw_item_t w;
    w.kind          = k;
    w.slot          = 3'($urandom_range(0, 7));
    w.byte_value    = 8'($urandom_range(0, 255));
    w.start_address = 8'($urandom_range(0, 255));
    w.byte_count    = 3'($urandom_range(0, 7));
    w.dio_sample    = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic plan_row_t word_row(logic [1:0] k, logic [2:0] slot, logic [7:0] bval,
                                         logic [7:0] addr, logic [2:0] cnt, bit typed,
                                         ldsw_res_t want, after_e after);
    plan_row_t row;
    row.op                 = ROW_WORD;
    row.word.kind          = k;
    row.word.slot          = slot;
    row.word.byte_value    = bval;
    row.word.start_address = addr;
    row.word.byte_count    = cnt;
    row.word.dio_sample    = 1'b0;
    row.typed              = typed;
    row.want               = want;
    row.after              = after;
    row.reg_idx            = '0;
    row.reg_val            = '0;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row         = word_row(KIND_TICK, 3'd0, 8'd0, 8'd0, 3'd0, 1'b0, RES_IDLE, AFTER_NONE);
    row.op      = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic push_word(ldsw_item_t w, bit typed = 1'b0, ldsw_res_t want = '0);
    ldsw_res_t predicted;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= w.kind;
    in_ch.slot          <= w.slot;
    in_ch.byte_value    <= w.byte_value;
    in_ch.start_address <= w.start_address;
    in_ch.byte_count    <= w.byte_count;
    in_ch.dio_sample    <= w.dio_sample;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_word(w);
    expected_lines.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    hold_until_drained();
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_DATA_COMMAND:    cmd_byte  = val[7:0];
      CFG_DISPLAY_CONTROL: ctl_byte  = val[7:0];
      CFG_ACK_WAIT_MAX:    ack_limit = val[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  // Tick until the transfer ends; high_pct sets how often the driver fails to
  // pull DIO low on an acknowledge sample.
  task automatic run_to_idle(int high_pct, int noise_pct);
    ldsw_item_t w;
    bit         sampling;
    while (sq_phase != SQ_IDLE) begin
      if (hold_once && sq_phase == SQ_BIT_HIGH) begin
        hold_once = 1'b0;
        hold_until_drained();
      end
      if ($urandom_range(0, 99) < noise_pct) begin
        // load, start or unused kind while busy: must be dropped
        w = rand_item(2'($urandom_range(1, 3)));
      end else begin
        sampling = (sq_phase == SQ_ACK_WAIT) || (sq_phase == SQ_ACK_SETTLE && sq_dly == 3'd0);
        w = rand_item(KIND_TICK);
        if (sampling) w.dio_sample = ($urandom_range(0, 99) < high_pct);
      end
      push_word(w);
    end
  endtask

  task automatic run_episode();
    ldsw_item_t w;
    int         high_pct;
    repeat ($urandom_range(0, 4)) push_word(rand_item(KIND_LOAD));
    if ($urandom_range(0, 4) == 0) push_word(rand_item($urandom_range(0, 1) ? KIND_UNUSED : KIND_TICK));
    w = rand_item(KIND_START);
    w.byte_count = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
    push_word(w);
    high_pct = (ack_limit == 1) ? 8 : 15 * $urandom_range(0, 3);
    run_to_idle(high_pct, 4);
  endtask

  function automatic void check_field(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side
  initial begin
    ldsw_res_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_lines.size() == 0) begin
          $error("result word with no expectation pending");
          mismatches++;
        end else begin
          want = expected_lines.pop_front();
          check_field("clk_line", want.clk_line, out_ch.clk_line);
          check_field("dio_line", want.dio_line, out_ch.dio_line);
          check_field("busy_res", want.busy_res, out_ch.busy_res);
          check_field("done_res", want.done_res, out_ch.done_res);
          check_field("ack_fail", want.ack_fail, out_ch.ack_fail);
          words_checked++;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("led_driver_serial_write_sequencer test failed");
      $finish;
    end
  end

  initial begin
    int goal;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_TICK;
    in_ch.slot          <= '0;
    in_ch.byte_value    <= '0;
    in_ch.start_address <= '0;
    in_ch.byte_count    <= '0;
    in_ch.dio_sample    <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_DATA_COMMAND;
    cfg_ch.data         <= '0;

    cmd_byte    = DATA_COMMAND_RST;
    ctl_byte    = DISPLAY_CONTROL_RST;
    ack_limit   = ACK_WAIT_MAX_RST;
    sq_phase    = SQ_IDLE;
    sq_dly      = '0;
    sq_bit      = '0;
    sq_byte_idx = '0;
    sq_shift    = '0;
    sq_wait     = '0;
    sq_addr     = '0;
    sq_cnt      = '0;
    sq_frame    = '0;
    line_clk    = 1'b1;
    line_dio    = 1'b1;
    fail_flag   = 1'b0;
    foreach (seg_buf[i]) seg_buf[i] = '0;

    // every slot is loaded up front so no transfer ever reads an unwritten byte
    plan.push_back(word_row(KIND_UNUSED, 3'd0, 8'h00, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_TICK,   3'd0, 8'h00, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_LOAD,   3'd0, 8'h00, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_LOAD,   3'd1, 8'hFF, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_LOAD,   3'd2, 8'h01, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_LOAD,   3'd3, 8'h80, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_LOAD,   3'd4, 8'hAA, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_LOAD,   3'd5, 8'h55, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_LOAD,   3'd7, 8'hFF, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_LOAD,   3'd6, 8'h5A, 8'h00, 3'd0, 1'b1, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_START,  3'd0, 8'h00, 8'hC0, 3'd0, 1'b1, RES_START, AFTER_NONE));
    plan.push_back(word_row(KIND_LOAD,   3'd0, 8'h12, 8'h00, 3'd0, 1'b0, RES_IDLE, AFTER_NONE));
    plan.push_back(word_row(KIND_START,  3'd0, 8'h00, 8'h00, 3'd3, 1'b0, RES_IDLE, AFTER_ACK));
    plan.push_back(word_row(KIND_START,  3'd0, 8'h00, 8'hFF, 3'd7, 1'b1, RES_START, AFTER_ACK));
    plan.push_back(reg_row(CFG_DATA_COMMAND, 27'hFF));
    plan.push_back(reg_row(CFG_DISPLAY_CONTROL, 27'h00));
    plan.push_back(reg_row(CFG_ACK_WAIT_MAX, 27'd1));
    plan.push_back(word_row(KIND_START,  3'd0, 8'h00, 8'h55, 3'd6, 1'b1, RES_START, AFTER_SILENT));
    plan.push_back(word_row(KIND_UNUSED, 3'd0, 8'h00, 8'h00, 3'd0, 1'b1, RES_ABORTED, AFTER_NONE));
    plan.push_back(reg_row(CFG_ACK_WAIT_MAX, ACK_LIMIT_MAX));
    plan.push_back(reg_row(CFG_DATA_COMMAND, 27'h00));
    plan.push_back(reg_row(CFG_DISPLAY_CONTROL, 27'hFF));
    plan.push_back(word_row(KIND_START,  3'd0, 8'h00, 8'h01, 3'd1, 1'b1, RES_START, AFTER_ACK));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].op == ROW_REG) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_word(plan[i].word, plan[i].typed, plan[i].want);
        case (plan[i].after)
          AFTER_ACK:    run_to_idle(0, 0);
          AFTER_SILENT: run_to_idle(100, 0);
          default: ;
        endcase
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_gap_pct   = 25;
          recv_stall_pct = 46;
        end
        1: begin
          send_gap_pct   = 46;
          recv_stall_pct = 25;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_reg(CFG_DATA_COMMAND, 27'($urandom_range(0, 255)));
      write_reg(CFG_DISPLAY_CONTROL, 27'($urandom_range(0, 255)));
      case (mode)
        0:       write_reg(CFG_ACK_WAIT_MAX, 27'($urandom_range(2, 5)));
        1:       write_reg(CFG_ACK_WAIT_MAX, 27'd1);
        default: write_reg(CFG_ACK_WAIT_MAX, ACK_LIMIT_MAX);
      endcase
      goal = words_sent + RAND_PER_MODE;
      while (words_sent < goal) run_episode();
    end

    hold_until_drained();
    repeat (4) @(posedge clk);
    $display("Drove %0d input words, checked %0d result words across three stall mixes",
             words_sent, words_checked);
    $display("Transfers completed: %0d, aborted on acknowledge timeout: %0d",
             transfers_done, aborts);
    if (mismatches == 0) begin
      $display("led_driver_serial_write_sequencer test passed");
    end else begin
      $display("led_driver_serial_write_sequencer test failed");
    end
    $finish;
  end

endmodule
